[hw/rtl/lmbs_pkg.sv]
`timescale 1ns / 1ps

package lmbs_pkg;

  // Display geometry
  localparam int NUM_PLANES    = 3;
  localparam int NUM_SCAN_ROWS = 16;

  // Internal widths
  localparam int PLANE_W    = 2;
  localparam int ROW_W      = $clog2(NUM_SCAN_ROWS);
  localparam int STORE_ROWS = NUM_PLANES * NUM_SCAN_ROWS;
  localparam int ADDR_W     = $clog2(STORE_ROWS);

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DWELL0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLACE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ROW = 3'd5;

  localparam logic [7:0] DWELL0_RST = 8'd3;
  localparam logic [7:0] DWELL1_RST = 8'd4;
  localparam logic [7:0] DWELL2_RST = 8'd22;

  // Column modes
  localparam logic [1:0] COL_DIRECT      = 2'd0;
  localparam logic [1:0] COL_REVERSED    = 2'd1;
  localparam logic [1:0] COL_INTERLEAVED = 2'd2;

  // Operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic [7:0] dwell0;
    logic [7:0] dwell1;
    logic [7:0] dwell2;
    logic [1:0] column_mode;
    logic       interlace_en;
    logic       row_inv;
  } lmbs_cfg_t;

  typedef struct packed {
    logic       operation;
    logic [1:0] plane_sel;
    logic [3:0] row_sel;
    logic       byte_sel;
    logic [7:0] pixel_byte;
  } lmbs_in_t;

  typedef struct packed {
    logic [7:0] col_port_a;
    logic [7:0] col_port_b;
    logic       row_step;
    logic       row_data;
    logic [7:0] dwell;
    logic [3:0] scan_row;
    logic [1:0] scan_plane;
  } lmbs_out_t;

  // One classified tick word on its way to the back end
  typedef struct packed {
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic               step;
    logic               data;
    logic [ROW_W-1:0]   row;
    logic [PLANE_W-1:0] plane;
  } lmbs_tick_t;

  // Mirror a byte
  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // Interleave two nibbles: ev into even bits, od into odd bits
  function automatic logic [7:0] weave4(input logic [3:0] ev, input logic [3:0] od);
    logic [7:0] r;
    for (int k = 0; k < 4; k++) begin
      r[2*k]   = ev[k];
      r[2*k+1] = od[k];
    end
    return r;
  endfunction

endpackage

[hw/rtl/lmbs_front.sv]
`timescale 1ns / 1ps

module lmbs_front import lmbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lmbs_cfg_t  cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  lmbs_in_t   in_data,
  output logic       q_push,
  output lmbs_tick_t q_wdata,
  input  logic       q_full
);

  logic               in_acc;
  logic               tick_acc;
  logic               wr_acc;
  logic               wr_hit;
  logic [PLANE_W:0]   plane_inc;
  logic [ROW_W:0]     row_inc;
  logic               step;
  logic               row_bit;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ROW_W-1:0]   phys_row;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;

  logic [7:0]            mem_lo [STORE_ROWS];
  logic [7:0]            mem_hi [STORE_ROWS];
  logic [STORE_ROWS-1:0] vld_lo_r;
  logic [STORE_ROWS-1:0] vld_hi_r;

  logic [7:0]         rd_lo_r, rd_hi_r;
  logic               rd_vld_lo_r, rd_vld_hi_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_step_r, s1_data_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [PLANE_W-1:0] s1_plane_r;

  // Accept while the stage is free or about to drain into the queue
  assign in_ready = !s1_valid_r || !q_full;
  assign in_acc   = in_valid && in_ready;
  assign tick_acc = in_acc && (in_data.operation == OP_TICK);
  assign wr_acc   = in_acc && (in_data.operation == OP_WRITE);

  // Advance plane and row counters
  always_comb begin
    plane_inc = {1'b0, plane_r} + (PLANE_W+1)'(1);
    row_inc   = {1'b0, row_r} + (ROW_W+1)'(1);
    step      = (plane_inc >= (PLANE_W+1)'(NUM_PLANES));
    plane_nxt = step ? '0 : plane_inc[PLANE_W-1:0];
    row_nxt   = row_r;
    if (step) begin
      row_nxt = (row_inc >= (ROW_W+1)'(NUM_SCAN_ROWS)) ? '0 : row_inc[ROW_W-1:0];
    end
    row_bit = (step && (row_nxt == '0)) ^ cfg.row_inv;
  end

  // Map scan row to stored row and form store addresses
  always_comb begin
    phys_row = row_nxt;
    if (cfg.interlace_en) begin
      phys_row = (row_nxt >> 1) + (row_nxt[0] ? ROW_W'(NUM_SCAN_ROWS / 2) : '0);
    end
    rd_addr = ADDR_W'(int'(plane_nxt) * NUM_SCAN_ROWS + int'(phys_row));
    wr_hit  = (int'(in_data.plane_sel) < NUM_PLANES) &&
              (int'(in_data.row_sel) < NUM_SCAN_ROWS);
    wr_addr = ADDR_W'(int'(in_data.plane_sel) * NUM_SCAN_ROWS + int'(in_data.row_sel));
  end

  // Frame store: one byte lane per column half, registered read
  always_ff @(posedge clk) begin
    if (wr_acc && wr_hit) begin
      if (in_data.byte_sel) begin
        mem_hi[wr_addr] <= in_data.pixel_byte;
      end else begin
        mem_lo[wr_addr] <= in_data.pixel_byte;
      end
    end
    if (tick_acc) begin
      rd_lo_r     <= mem_lo[rd_addr];
      rd_hi_r     <= mem_hi[rd_addr];
      rd_vld_lo_r <= vld_lo_r[rd_addr];
      rd_vld_hi_r <= vld_hi_r[rd_addr];
      s1_step_r   <= step;
      s1_data_r   <= row_bit;
      s1_row_r    <= row_nxt;
      s1_plane_r  <= plane_nxt;
    end
  end

  // Written marks: an unwritten byte reads as dark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_lo_r <= '0;
      vld_hi_r <= '0;
    end else if (wr_acc && wr_hit) begin
      if (in_data.byte_sel) begin
        vld_hi_r[wr_addr] <= 1'b1;
      end else begin
        vld_lo_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Hand the stage word to the queue
  assign q_push        = s1_valid_r && !q_full;
  assign q_wdata.b0    = rd_vld_lo_r ? rd_lo_r : '0;
  assign q_wdata.b1    = rd_vld_hi_r ? rd_hi_r : '0;
  assign q_wdata.step  = s1_step_r;
  assign q_wdata.data  = s1_data_r;
  assign q_wdata.row   = s1_row_r;
  assign q_wdata.plane = s1_plane_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (tick_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Hold counters and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r    <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (tick_acc) begin
        plane_r <= plane_nxt;
        row_r   <= row_nxt;
      end
    end
  end

endmodule

[hw/rtl/lmbs_fifo.sv]
`timescale 1ns / 1ps

module lmbs_fifo import lmbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lmbs_tick_t wdata,
  output logic       full,
  input  logic       pop,
  output lmbs_tick_t rdata,
  output logic       empty
);

  lmbs_tick_t        ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rd_ptr_r];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

[hw/rtl/lmbs_back.sv]
`timescale 1ns / 1ps

module lmbs_back import lmbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lmbs_cfg_t  cfg,
  input  lmbs_tick_t q_rdata,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output lmbs_out_t  out_data
);

  lmbs_out_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ROW_W+3:0] row_ext;

  // Take a word whenever the output register is free or draining
  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  // Format column bytes and pick the dwell for the plane
  always_comb begin
    out_nxt = '0;
    unique case (cfg.column_mode)
      COL_REVERSED: begin
        out_nxt.col_port_a = bit_rev8(q_rdata.b1);
        out_nxt.col_port_b = bit_rev8(q_rdata.b0);
      end
      COL_INTERLEAVED: begin
        out_nxt.col_port_a = weave4(q_rdata.b0[3:0], q_rdata.b1[3:0]);
        out_nxt.col_port_b = weave4(q_rdata.b0[7:4], q_rdata.b1[7:4]);
      end
      default: begin
        out_nxt.col_port_a = q_rdata.b0;
        out_nxt.col_port_b = q_rdata.b1;
      end
    endcase
    case (q_rdata.plane)
      2'd0:    out_nxt.dwell = cfg.dwell0;
      2'd1:    out_nxt.dwell = cfg.dwell1;
      default: out_nxt.dwell = cfg.dwell2;
    endcase
    row_ext             = {4'b0000, q_rdata.row};
    out_nxt.row_step    = q_rdata.step;
    out_nxt.row_data    = q_rdata.data;
    out_nxt.scan_row    = row_ext[3:0];
    out_nxt.scan_plane  = q_rdata.plane;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/led_matrix_bitplane_scanner.sv]
`timescale 1ns / 1ps

// Bit-plane row scanner for a 16-column LED matrix.
// Input channel (in_valid/in_ready/in_data): a write word stores one frame
// byte at (plane, row, column half) and yields no result; a tick word
// advances plane and row counters and yields one result word on the output
// channel (out_valid/out_ready/out_data) with the two column port bytes,
// the row step and row data bits, the dwell compare value and the counters.
// Configuration: cfg_we writes cfg_wdata to register cfg_index;
// write only while no tick is in flight.
// Path: a tick's result is registered by the store read at acceptance, then
// written into the queue, then loaded into the output register. Throughput
// is one word per cycle while the receiver keeps out_ready high.
// Reset: counters at zero, registers at defaults, the frame store reads as
// all zero through per-byte written marks, so no clearing pass is needed and
// in_ready is high as soon as reset is released.
// Stall: a stalled receiver holds out_data; up to a stage word, two queued
// words and the output word build up before in_ready drops.
module led_matrix_bitplane_scanner import lmbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lmbs_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lmbs_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  lmbs_cfg_t  cfg_r, cfg_nxt;
  logic       q_push, q_pop, q_full, q_empty;
  lmbs_tick_t q_wdata, q_rdata;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DWELL0:     cfg_nxt.dwell0       = cfg_wdata;
        CFG_DWELL1:     cfg_nxt.dwell1       = cfg_wdata;
        CFG_DWELL2:     cfg_nxt.dwell2       = cfg_wdata;
        CFG_COL_MODE:   cfg_nxt.column_mode  = cfg_wdata[1:0];
        CFG_INTERLACE:  cfg_nxt.interlace_en = cfg_wdata[0];
        CFG_INVERT_ROW: cfg_nxt.row_inv      = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dwell0       <= DWELL0_RST;
      cfg_r.dwell1       <= DWELL1_RST;
      cfg_r.dwell2       <= DWELL2_RST;
      cfg_r.column_mode  <= COL_DIRECT;
      cfg_r.interlace_en <= 1'b0;
      cfg_r.row_inv      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lmbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  lmbs_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  lmbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/lmbs_checker.sv]
`timescale 1ns / 1ps

module lmbs_checker import lmbs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input lmbs_out_t out_data
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A row step exactly when the plane wrapped to zero
  a_step_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.row_step == (out_data.scan_plane == 2'd0)))
    else $error("row step disagrees with plane counter");

  // A word without a row step never shows plane zero
  a_step_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.row_step |-> out_data.scan_plane != 2'd0)
    else $error("plane zero shown without a row step");

  // Reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind led_matrix_bitplane_scanner lmbs_checker u_lmbs_checker (.*);
